// File: hdl/lfp_pkg.sv
// Shared types and constants of the LED frame packetizer.
package lfp_pkg;

  // Default frame geometry.
  localparam int LFP_COLUMNS         = 41;
  localparam int LFP_ROWS            = 24;
  localparam int LFP_ROWS_PER_PACKET = 4;

  // Width of one color channel.
  localparam int CHAN_W = 8;

  // Full-scale intensity used by the scaling arithmetic.
  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

  // Bit steps of the iterative unscale divider (dividend is 16 bits).
  localparam int DIV_STEPS = 2 * CHAN_W;

  // Start pulses from the controller to the color lanes.
  typedef struct packed {
    logic scale_go;
    logic unscale_go;
  } lane_ctl_t;

endpackage

// File: hdl/lfp_lane.sv
// One color lane: brightness scaling on write and iterative unscaling on read.
module lfp_lane
  import lfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctl_t         ctl_i,
  input  logic [CHAN_W-1:0] value_i,
  input  logic [CHAN_W-1:0] factor_i,
  input  logic [CHAN_W-1:0] stored_i,
  output logic [CHAN_W-1:0] scaled_o,
  output logic [CHAN_W-1:0] unscaled_o,
  output logic              busy_o
);

  localparam int PW = 2 * CHAN_W;
  localparam int CW = $clog2(DIV_STEPS);

  logic [PW-1:0]     prod_q;
  logic [CHAN_W-1:0] scaled_q, scaled_d;
  logic [PW+CHAN_W-1:0] recip;
  logic [CHAN_W-1:0] q0;
  logic [PW-1:0]     q0_times;
  logic [PW-1:0]     resid;

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     quot_q, quot_d;
  logic [CHAN_W-1:0] rem_q, rem_d;
  logic [CHAN_W-1:0] div_q, div_d;
  logic [CHAN_W:0]   rem_sh;
  logic [PW-1:0]     dividend;

  // Product of the value and the factor (the limit, or half of it), registered before the divide by 255.
  always_ff @(posedge clk_i) begin
    if (ctl_i.scale_go) begin
      prod_q <= PW'(value_i) * PW'(factor_i);
    end
    scaled_q <= scaled_d;
  end

  // Divide by 255: multiply by 257/65536, then one correction step.
  always_comb begin
    recip    = {prod_q, 8'b0} + (PW+CHAN_W)'(prod_q);
    q0       = recip[PW+CHAN_W-1:PW];
    q0_times = {q0, 8'b0} - PW'(q0);
    resid    = prod_q - q0_times;
    scaled_d = (resid >= PW'(FULL_SCALE)) ? q0 + 1'b1 : q0;
  end

  assign scaled_o = scaled_q;

  // Restoring divider for stored * 255 / divisor, one quotient bit a cycle.
  always_comb begin
    dividend = {stored_i, 8'b0} - PW'(stored_i);
    rem_sh   = {rem_q, quot_q[PW-1]};
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    div_d    = div_q;
    if (ctl_i.unscale_go) begin
      div_d = factor_i;
      rem_d = '0;
      cnt_d = '0;
      if (factor_i == '0) begin
        quot_d = '0;
        busy_d = 1'b0;
      end else begin
        quot_d = dividend;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d  = CHAN_W'(rem_sh - {1'b0, div_q});
        quot_d = {quot_q[PW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[CHAN_W-1:0];
        quot_d = {quot_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  // Results above full scale saturate.
  assign unscaled_o = (|quot_q[PW-1:CHAN_W]) ? FULL_SCALE : quot_q[CHAN_W-1:0];
  assign busy_o     = busy_q;

endmodule

// File: hdl/lfp_store.sv
// Pixel frame memory with a clearing sweep after reset and on request.
module lfp_store
  import lfp_pkg::*;
#(
  parameter int DEPTH = LFP_COLUMNS * LFP_ROWS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  output logic                     clearing_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [3*CHAN_W-1:0]      wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [3*CHAN_W-1:0]      rd_data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [3*CHAN_W-1:0] mem [DEPTH];
  logic [3*CHAN_W-1:0] rd_data_q;
  logic                clr_busy_q, clr_busy_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [3*CHAN_W-1:0] wdata;

  // Sweep control: one entry zeroed per cycle.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end else if (clear_i) begin
      clr_busy_d = 1'b1;
      clr_addr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port while it runs.
  assign we    = clr_busy_q || wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_busy_q;

endmodule

// File: hdl/lfp_merge.sv
// Merge stage: combines lane results and the fetched byte into the output register.
module lfp_merge
  import lfp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   get_ok_i,
  input  logic                   is_fetch_i,
  input  logic [2:0][CHAN_W-1:0] lane_val_i,
  input  logic [CHAN_W-1:0]      pbyte_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAN_W-1:0]      read_red_o,
  output logic [CHAN_W-1:0]      read_green_o,
  output logic [CHAN_W-1:0]      read_blue_o,
  output logic [CHAN_W-1:0]      packet_byte_o
);

  logic              valid_q, valid_d;
  logic [CHAN_W-1:0] red_q, green_q, blue_q, pbyte_q;
  logic              use_lanes;

  assign free_o    = !valid_q || !out_stall_i;
  assign use_lanes = get_ok_i && !is_fetch_i;

  // Valid holds while the receiver stalls.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Fields not produced by the item kind read as zero.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      red_q   <= use_lanes ? lane_val_i[2] : '0;
      green_q <= use_lanes ? lane_val_i[1] : '0;
      blue_q  <= use_lanes ? lane_val_i[0] : '0;
      pbyte_q <= is_fetch_i ? pbyte_i : '0;
    end
  end

  assign out_valid_o   = valid_q;
  assign read_red_o    = red_q;
  assign read_green_o  = green_q;
  assign read_blue_o   = blue_q;
  assign packet_byte_o = pbyte_q;

endmodule

// File: hdl/led_frame_packetizer.sv
// Top level of the LED frame packetizer: controller, color lanes, store and merge.
//
// Input words carry a kind (set, get, clear, fetch) with pixel coordinates,
// colors, a packet index and a byte offset; they are taken on valid and not
// stall. One word is worked on at a time. Get and fetch words return one
// result word on the output channel; set and clear return none.
// Steps per word, from acceptance until the block takes the next:
//   set   multiply, divide by 255, memory write,
//   get   memory read, then the bit-serial unscale divider
//         that the three color lanes run side by side,
//   fetch address decode, memory read, byte select,
//   clear decode, then a sweep of COLUMNS*ROWS entries (984 by default)
//         through the single memory write port.
// After reset the same sweep zeroes the frame; input stall stays high until
// it ends, while brightness_limit writes are taken at any time.
// The brightness limit resets to 255 and is written by cfg_we_i.
// A finished result waits in the output register while the receiver stalls;
// the block may accept the next word meanwhile, but a result of that word
// is held back until the output register is free.
module led_frame_packetizer
  import lfp_pkg::*;
#(
  parameter int COLUMNS         = LFP_COLUMNS,
  parameter int ROWS            = LFP_ROWS,
  parameter int ROWS_PER_PACKET = LFP_ROWS_PER_PACKET
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  pixel_x_i,
  input  logic [4:0]  pixel_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [2:0]  packet_index_i,
  input  logic [8:0]  byte_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_red_o,
  output logic [7:0]  read_green_o,
  output logic [7:0]  read_blue_o,
  output logic [7:0]  packet_byte_o
);

  localparam int PIXELS       = COLUMNS * ROWS;
  localparam int PACKET_COUNT = (ROWS + ROWS_PER_PACKET - 1) / ROWS_PER_PACKET;
  localparam int PKT_PIXELS   = ROWS_PER_PACKET * COLUMNS;
  localparam int PACKET_BYTES = PKT_PIXELS * 3 + 1;
  localparam int AW           = $clog2(PIXELS);
  localparam int GW           = $clog2(32 * COLUMNS + 64);
  localparam int FW           = $clog2(8 * PKT_PIXELS + 256);

  // Reciprocal of 3 for offsets below 512: k/3 = (k*683) >> 11.
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SET_WAIT = 3'd2;
  localparam logic [2:0] S_SET_WR   = 3'd3;
  localparam logic [2:0] S_LOAD     = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  localparam logic [2:0] SRC_ZERO  = 3'd0;
  localparam logic [2:0] SRC_HDR   = 3'd1;
  localparam logic [2:0] SRC_BLUE  = 3'd2;
  localparam logic [2:0] SRC_GREEN = 3'd3;
  localparam logic [2:0] SRC_RED   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [7:0] limit_q;
  logic [7:0] half_limit;

  logic [1:0] kind_q;
  logic [5:0] x_q;
  logic [4:0] y_q;
  logic [7:0] red_q, green_q, blue_q;
  logic [2:0] pkt_q;
  logic [8:0] off_q;

  logic [2:0] src_q, src_d;
  logic [7:0] hdr_q, hdr_d;
  logic       get_ok_q, get_ok_d;
  logic [7:0] pbyte_q, pbyte_d;

  logic       in_accept;
  logic       in_frame;
  logic [GW-1:0] pix_addr_w;
  logic [8:0]    k;
  logic [18:0]   k_recip;
  logic [7:0]    pix;
  logic [9:0]    pix_times3;
  logic [1:0]    ch;
  logic [FW-1:0] fetch_addr_w;
  logic          fetch_ok;
  logic          row_ok;

  lane_ctl_t              lane_ctl;
  logic [2:0][CHAN_W-1:0] lane_value, lane_factor, lane_scaled, lane_unscaled;
  logic [2:0]             lane_busy;

  logic                clearing;
  logic                clear_go;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [3*CHAN_W-1:0] mem_rdata;

  logic merge_free;
  logic merge_load;

  // Brightness limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= FULL_SCALE;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign half_limit = limit_q >> 1;

  // Input word capture.
  assign in_stall_o = (state_q != S_IDLE) || clearing;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      pkt_q   <= packet_index_i;
      off_q   <= byte_offset_i;
    end
  end

  // Pixel address for set and get.
  assign in_frame   = (32'(x_q) < COLUMNS) && (32'(y_q) < ROWS);
  assign pix_addr_w = GW'(y_q) * GW'(COLUMNS) + GW'(x_q);

  // Fetch decode: pixel within the packet and channel within the pixel.
  always_comb begin
    k            = off_q - 9'd1;
    k_recip      = 19'(k) * 19'(RECIP3);
    pix          = 8'(k_recip >> RECIP3_SHIFT);
    pix_times3   = {1'b0, pix, 1'b0} + 10'(pix);
    ch           = 2'(10'(k) - pix_times3);
    fetch_addr_w = FW'(pkt_q) * FW'(PKT_PIXELS) + FW'(pix);
    fetch_ok     = (32'(pkt_q) < PACKET_COUNT) && (32'(off_q) < PACKET_BYTES);
    row_ok       = 32'(fetch_addr_w) < PIXELS;
    hdr_d        = 8'(32'(pkt_q) * ROWS_PER_PACKET);
  end

  // Lane inputs: lane 0 blue, lane 1 green, lane 2 red.
  assign lane_value  = {red_q, green_q, blue_q};
  assign lane_factor = {limit_q, limit_q, half_limit};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lfp_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .value_i    (lane_value[i]),
      .factor_i   (lane_factor[i]),
      .stored_i   (mem_rdata[i*CHAN_W +: CHAN_W]),
      .scaled_o   (lane_scaled[i]),
      .unscaled_o (lane_unscaled[i]),
      .busy_o     (lane_busy[i])
    );
  end

  lfp_store #(
    .DEPTH (PIXELS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear_go),
    .clearing_o (clearing),
    .wr_en_i    (mem_we),
    .wr_addr_i  (AW'(pix_addr_w)),
    .wr_data_i  (lane_scaled),
    .rd_en_i    (mem_re),
    .rd_addr_i  (mem_raddr),
    .rd_data_o  (mem_rdata)
  );

  // Controller: one word at a time through decode, lane or memory work and, for gets and fetches, the result.
  always_comb begin
    state_d             = state_q;
    src_d               = src_q;
    get_ok_d            = get_ok_q;
    pbyte_d             = pbyte_q;
    lane_ctl.scale_go   = 1'b0;
    lane_ctl.unscale_go = 1'b0;
    clear_go            = 1'b0;
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    mem_raddr           = AW'(pix_addr_w);
    merge_load          = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (kind_q)
          KIND_SET: begin
            lane_ctl.scale_go = in_frame;
            state_d           = in_frame ? S_SET_WAIT : S_IDLE;
          end
          KIND_GET: begin
            get_ok_d = in_frame;
            mem_re   = in_frame;
            state_d  = in_frame ? S_LOAD : S_DONE;
          end
          KIND_CLEAR: begin
            clear_go = 1'b1;
            state_d  = S_IDLE;
          end
          KIND_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(fetch_addr_w);
            get_ok_d  = 1'b0;
            if (!fetch_ok) begin
              src_d = SRC_ZERO;
            end else if (off_q == '0) begin
              src_d = SRC_HDR;
            end else if (!row_ok) begin
              src_d = SRC_ZERO;
            end else begin
              case (ch)
                2'd0:    src_d = SRC_BLUE;
                2'd1:    src_d = SRC_GREEN;
                2'd2:    src_d = SRC_RED;
                default: src_d = SRC_ZERO;
              endcase
            end
            state_d = S_LOAD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SET_WAIT: begin
        state_d = S_SET_WR;
      end
      S_SET_WR: begin
        mem_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_LOAD: begin
        if (kind_q == KIND_GET) begin
          lane_ctl.unscale_go = 1'b1;
          state_d             = S_DIV;
        end else begin
          case (src_q)
            SRC_HDR:   pbyte_d = hdr_q;
            SRC_BLUE:  pbyte_d = mem_rdata[7:0];
            SRC_GREEN: pbyte_d = mem_rdata[15:8];
            SRC_RED:   pbyte_d = mem_rdata[23:16];
            default:   pbyte_d = '0;
          endcase
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (lane_busy == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    hdr_q    <= hdr_d;
    get_ok_q <= get_ok_d;
    pbyte_q  <= pbyte_d;
  end

  lfp_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (merge_load),
    .get_ok_i      (get_ok_q),
    .is_fetch_i    (kind_q == KIND_FETCH),
    .lane_val_i    (lane_unscaled),
    .pbyte_i       (pbyte_q),
    .free_o        (merge_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_red_o    (read_red_o),
    .read_green_o  (read_green_o),
    .read_blue_o   (read_blue_o),
    .packet_byte_o (packet_byte_o)
  );

  // A host write to the store never collides with the clear sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> !clearing)
    else $error("pixel write during clear sweep");

  // The lane dividers only run while the controller waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_busy != '0) |-> (state_q == S_DIV))
    else $error("lane divider busy outside divide wait");

  // A newly accepted word always finds the lanes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (lane_busy == '0))
    else $error("word accepted while lanes busy");

  // Byte selection only follows a memory read issued in decode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> ($past(state_q) == S_DECODE))
    else $error("load state entered without a read");

endmodule

// File: tb/led_frame_packetizer_checker.sv
// Word codes for the testbench and a checker that predicts and compares result words.
`timescale 1ns / 1ps

package lfp_tb_pkg;
  import lfp_pkg::*;

  // Kinds of input word.
  typedef enum logic [1:0] {
    WORD_SET   = 2'd0,
    WORD_GET   = 2'd1,
    WORD_CLEAR = 2'd2,
    WORD_FETCH = 2'd3
  } word_kind_e;

  // Frame and packet geometry derived from the defaults of the block.
  localparam int FRAME_PIXELS = LFP_COLUMNS * LFP_ROWS;
  localparam int PACKET_COUNT = (LFP_ROWS + LFP_ROWS_PER_PACKET - 1) / LFP_ROWS_PER_PACKET;
  localparam int PACKET_BYTES = LFP_ROWS_PER_PACKET * LFP_COLUMNS * 3 + 1;

  // One result word.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] pbyte;
  } reply_t;
endpackage

module led_frame_packetizer_checker
  import lfp_pkg::*;
  import lfp_tb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] kind_i,
  input  logic [5:0] pixel_x_i,
  input  logic [4:0] pixel_y_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [2:0] packet_index_i,
  input  logic [8:0] byte_offset_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] read_red_i,
  input  logic [7:0] read_green_i,
  input  logic [7:0] read_blue_i,
  input  logic [7:0] packet_byte_i,
  output int         mismatches_o,
  output int         pending_o
);

  // Own copy of the scaled frame and of the brightness limit.
  logic [23:0] frame_copy [FRAME_PIXELS];
  logic [7:0]  limit_copy;
  reply_t      awaited_replies [$];
  int          mismatch_count = 0;
  int          pending_count  = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Undoes the scaling of one stored channel; a zero divisor reads as 0.
  function automatic logic [7:0] unscale_chan(input logic [7:0] stored,
                                              input logic [7:0] divisor);
    logic [15:0] q;
    if (divisor == 8'd0) begin
      return 8'd0;
    end
    q = (16'(stored) * 16'(FULL_SCALE)) / 16'(divisor);
    return (q > 16'd255) ? 8'hFF : q[7:0];
  endfunction

  // Applies one word to the frame copy; returns 1 when the word has a result.
  function automatic bit predict_reply(input word_kind_e kind, input logic [5:0] x,
                                       input logic [4:0] y, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       input logic [2:0] p, input logic [8:0] off,
                                       output reply_t reply);
    logic [7:0]  half;
    logic [15:0] sr, sg, sb;
    logic [23:0] w;
    int          k, pix, row, col;
    bit          inside_frame, has_reply;
    half         = limit_copy >> 1;
    inside_frame = (x < LFP_COLUMNS) && (y < LFP_ROWS);
    reply        = '0;
    has_reply    = 1'b0;
    case (kind)
      WORD_SET: begin
        if (inside_frame) begin
          sr = (16'(r) * 16'(limit_copy)) / 16'(FULL_SCALE);
          sg = (16'(g) * 16'(limit_copy)) / 16'(FULL_SCALE);
          sb = (16'(b) * 16'(half)) / 16'(FULL_SCALE);
          frame_copy[int'(y) * LFP_COLUMNS + int'(x)] = {sr[7:0], sg[7:0], sb[7:0]};
        end
      end
      WORD_GET: begin
        has_reply = 1'b1;
        if (inside_frame) begin
          w           = frame_copy[int'(y) * LFP_COLUMNS + int'(x)];
          reply.red   = unscale_chan(w[23:16], limit_copy);
          reply.green = unscale_chan(w[15:8], limit_copy);
          reply.blue  = unscale_chan(w[7:0], half);
        end
      end
      WORD_CLEAR: begin
        foreach (frame_copy[i]) frame_copy[i] = '0;
      end
      default: begin
        // Fetch: header byte, then blue, green, red triples row by row.
        has_reply = 1'b1;
        if (p < PACKET_COUNT && off < PACKET_BYTES) begin
          if (off == 9'd0) begin
            reply.pbyte = 8'(int'(p) * LFP_ROWS_PER_PACKET);
          end else begin
            k   = int'(off) - 1;
            pix = k / 3;
            row = int'(p) * LFP_ROWS_PER_PACKET + pix / LFP_COLUMNS;
            col = pix % LFP_COLUMNS;
            if (row < LFP_ROWS) begin
              w = frame_copy[row * LFP_COLUMNS + col];
              case (k % 3)
                0:       reply.pbyte = w[7:0];
                1:       reply.pbyte = w[15:8];
                default: reply.pbyte = w[23:16];
              endcase
            end
          end
        end
      end
    endcase
    return has_reply;
  endfunction

  // Watches both channels and the register port at every edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t got, want, predicted;
    if (!rst_ni) begin
      foreach (frame_copy[i]) frame_copy[i] = '0;
      limit_copy = FULL_SCALE;
      awaited_replies.delete();
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        limit_copy = cfg_wdata_i;
      end
      // Compare an accepted result word with the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        got = '{read_red_i, read_green_i, read_blue_i, packet_byte_i};
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("result with none expected: %0d %0d %0d byte %0d",
                                    got.red, got.green, got.blue, got.pbyte));
        end else begin
          want = awaited_replies.pop_front();
          if (got.red != want.red)
            report_mismatch($sformatf("read_red %0d, expected %0d", got.red, want.red));
          if (got.green != want.green)
            report_mismatch($sformatf("read_green %0d, expected %0d", got.green, want.green));
          if (got.blue != want.blue)
            report_mismatch($sformatf("read_blue %0d, expected %0d", got.blue, want.blue));
          if (got.pbyte != want.pbyte)
            report_mismatch($sformatf("packet_byte %0d, expected %0d", got.pbyte, want.pbyte));
        end
      end
      // Predict the outcome of an accepted input word.
      if (in_valid_i && !in_stall_i) begin
        if (predict_reply(word_kind_e'(kind_i), pixel_x_i, pixel_y_i, red_i, green_i,
                          blue_i, packet_index_i, byte_offset_i, predicted)) begin
          awaited_replies.push_back(predicted);
        end
      end
      pending_count = awaited_replies.size();
    end
  end

endmodule

// File: tb/tb_led_frame_packetizer.sv
// Testbench top of the LED frame packetizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_led_frame_packetizer;
  import lfp_pkg::*;
  import lfp_tb_pkg::*;

  localparam int SETTLE_CYCLES    = 1200;
  localparam int TIMEOUT_CYCLES   = 600000;
  localparam int PHASES           = 10;
  localparam int WORDS_PER_PHASE  = 100;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = 8'd0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [1:0] kind         = WORD_SET;
  logic [5:0] pixel_x      = '0;
  logic [4:0] pixel_y      = '0;
  logic [7:0] red          = '0;
  logic [7:0] green        = '0;
  logic [7:0] blue         = '0;
  logic [2:0] packet_index = '0;
  logic [8:0] byte_offset  = '0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] read_red, read_green, read_blue, packet_byte;
  int         mismatches, pending;
  bit         calm = 1'b0;
  int unsigned cycle_count = 0;

  // Pixels written recently, packed as {x, y}, so that gets and fetches hit them.
  logic [10:0] written_spots [$];

  led_frame_packetizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .packet_index_i (packet_index),
    .byte_offset_i  (byte_offset),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_red_o     (read_red),
    .read_green_o   (read_green),
    .read_blue_o    (read_blue),
    .packet_byte_o  (packet_byte)
  );

  led_frame_packetizer_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .packet_index_i (packet_index),
    .byte_offset_i  (byte_offset),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .read_red_i     (read_red),
    .read_green_i   (read_green),
    .read_blue_i    (read_blue),
    .packet_byte_i  (packet_byte),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the calm last phase.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Presents one word, after an optional random gap, and waits until it is taken.
  task automatic send_word(input word_kind_e k, input logic [5:0] x, input logic [4:0] y,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [2:0] p, input logic [8:0] off);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    pixel_x      <= x;
    pixel_y      <= y;
    red          <= r;
    green        <= g;
    blue         <= b;
    packet_index <= p;
    byte_offset  <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lets every result drain and any clear sweep finish, then writes the limit.
  task automatic set_limit(input logic [7:0] value);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus: directed words, then random phases at several brightness limits.
  initial begin
    logic [7:0]  phase_limits [PHASES];
    word_kind_e  k;
    logic [5:0]  x;
    logic [4:0]  y;
    logic [7:0]  r, g, b;
    logic [2:0]  p;
    logic [8:0]  off;
    logic [10:0] spot;
    int          pick, pix;

    phase_limits = '{8'd255, 8'd2, 8'd3, 8'd128, 8'd254, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255};
    phase_limits[7] = 8'($urandom_range(0, 255));
    phase_limits[8] = 8'($urandom_range(1, 255));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_limit(FULL_SCALE);

    // Corners of the frame, pixels outside it, and every fetch boundary.
    send_word(WORD_SET, 6'd0, 5'd0, 8'hFF, 8'hFF, 8'hFF, 3'd0, 9'd0);
    send_word(WORD_SET, 6'd40, 5'd23, 8'd170, 8'd85, 8'd1, 3'd7, 9'h1FF);
    send_word(WORD_SET, 6'd41, 5'd0, 8'd9, 8'd9, 8'd9, 3'd0, 9'd0);
    send_word(WORD_SET, 6'd63, 5'd31, 8'd7, 8'd7, 8'd7, 3'd0, 9'd0);
    send_word(WORD_SET, 6'd5, 5'd24, 8'd3, 8'd3, 8'd3, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd40, 5'd23, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd41, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd0, 5'd31, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd1);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd3);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd5, 9'd0);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd5, 9'(PACKET_BYTES - 1));
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd5, 9'(PACKET_BYTES));
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'(PACKET_COUNT), 9'd0);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd7, 9'h1FF);
    send_word(WORD_CLEAR, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_FETCH, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0, 3'd5, 9'(PACKET_BYTES - 1));
    send_word(WORD_SET, 6'd10, 5'd10, 8'hFF, 8'd128, 8'hFF, 3'd0, 9'd0);

    // Limit lowered after a set saturates, and a limit of 1 zeroes the blue divisor.
    set_limit(8'd1);
    send_word(WORD_GET, 6'd10, 5'd10, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_SET, 6'd3, 5'd3, 8'hFF, 8'hFF, 8'hFF, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd3, 5'd3, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);

    // A limit of zero stores zeros and reads back zeros.
    set_limit(8'd0);
    send_word(WORD_SET, 6'd3, 5'd3, 8'd200, 8'd100, 8'd50, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd3, 5'd3, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);
    send_word(WORD_GET, 6'd10, 5'd10, 8'd0, 8'd0, 8'd0, 3'd0, 9'd0);

    // Random phases: mostly in-frame sets, gets and fetches of written pixels.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        calm = 1'b1;
      end
      set_limit(phase_limits[ph]);
      repeat (WORDS_PER_PHASE) begin
        x    = 6'($urandom);
        y    = 5'($urandom);
        r    = 8'($urandom);
        g    = 8'($urandom);
        b    = 8'($urandom);
        p    = 3'($urandom);
        off  = 9'($urandom);
        spot = (written_spots.size() > 0) ?
               written_spots[$urandom_range(0, written_spots.size() - 1)] : '0;
        pick = $urandom_range(0, 199);
        if (pick < 2) begin
          k = WORD_CLEAR;
        end else if (pick < 76) begin
          k = WORD_SET;
          if ($urandom_range(0, 9) != 0) begin
            x = 6'($urandom_range(0, LFP_COLUMNS - 1));
            y = 5'($urandom_range(0, LFP_ROWS - 1));
          end
          // Now and then each channel is pushed to 0 or full scale.
          if ($urandom_range(0, 7) == 0) begin
            r = {8{r[0]}};
            g = {8{g[0]}};
            b = {8{b[0]}};
          end
          if (x < LFP_COLUMNS && y < LFP_ROWS) begin
            written_spots.push_back({x, y});
            if (written_spots.size() > 32) begin
              void'(written_spots.pop_front());
            end
          end
        end else if (pick < 136) begin
          k = WORD_GET;
          if ($urandom_range(0, 3) != 0) begin
            {x, y} = spot;
          end else if ($urandom_range(0, 1) == 0) begin
            x = 6'($urandom_range(0, LFP_COLUMNS - 1));
            y = 5'($urandom_range(0, LFP_ROWS - 1));
          end
        end else begin
          k    = WORD_FETCH;
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            // Address one channel of a written pixel through its packet.
            p   = 3'(spot[4:0] / LFP_ROWS_PER_PACKET);
            pix = (int'(spot[4:0]) % LFP_ROWS_PER_PACKET) * LFP_COLUMNS + int'(spot[10:5]);
            off = 9'(1 + pix * 3 + $urandom_range(0, 2));
          end else if (pick < 9) begin
            p   = 3'($urandom_range(0, PACKET_COUNT - 1));
            off = 9'($urandom_range(0, PACKET_BYTES - 1));
          end
        end
        send_word(k, x, y, r, g, b, p, off);
      end
    end

    // Drain the last results and give the block time to settle.
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: led_frame_packetizer.f
hdl/lfp_pkg.sv
hdl/lfp_lane.sv
hdl/lfp_store.sv
hdl/lfp_merge.sv
hdl/led_frame_packetizer.sv
tb/led_frame_packetizer_checker.sv
tb/tb_led_frame_packetizer.sv
